/* rtl/itp_pkg.sv */
package itp_pkg;

    // Character codes that steer the parse
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_X  = 8'h78;
    localparam logic [7:0] CHAR_UC_X  = 8'h58;

    // Bases
    localparam int          RADIX_W   = 6;
    localparam logic [5:0]  BASE_AUTO = 6'd0;
    localparam logic [5:0]  BASE_OCT  = 6'd8;
    localparam logic [5:0]  BASE_DEC  = 6'd10;
    localparam logic [5:0]  BASE_HEX  = 6'd16;
    localparam logic [5:0]  BASE_MAX  = 6'd36;
    localparam logic [5:0]  NOT_DIGIT = 6'd63;

    // Widths
    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 16;
    localparam longint unsigned MAX_CHARS = 65535;
    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CHARS);
    localparam logic [OFFSET_W-1:0] OFFSET_SAT = '1;

    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 1 + RADIX_W;
    localparam int M_DATA_W = ((VALUE_W + OFFSET_W + 7) / 8) * 8;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_SPACE  = 5'b00010,
        PH_BODY   = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]         ch;
        logic               start_req;
        logic [RADIX_W-1:0] radix;
    } in_item_t;

    typedef struct packed {
        phase_t              phase;
        logic [VALUE_W-1:0]  acc;
        logic                negative;
        logic [RADIX_W-1:0]  base;
        logic [CNT_W-1:0]    consumed;
    } parse_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] end_offset;
    } result_t;

    // Digit value of a character, NOT_DIGIT when it is none
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [5:0] d;
        d = NOT_DIGIT;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = 6'(c - CHAR_ZERO);
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            d = 6'(c - CHAR_LC_A) + 6'd10;
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            d = 6'(c - CHAR_UC_A) + 6'd10;
        end
        return d;
    endfunction

endpackage

/* rtl/itp_in_reg.sv */
module itp_in_reg
    import itp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  in_item_t item_in,
    input  logic     advance,
    output logic     valid,
    output in_item_t item_out
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Occupied after a load, freed when the step consumes it
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

/* rtl/itp_step.sv */
module itp_step
    import itp_pkg::*;
(
    input  parse_state_t st,
    input  in_item_t     item,
    output parse_state_t st_next,
    output logic         emit,
    output result_t      result
);

    phase_t             ph;
    logic [VALUE_W-1:0] acc;
    logic               neg;
    logic [RADIX_W-1:0] base;
    logic [CNT_W-1:0]   cnt;
    logic               done;
    logic               inc;
    logic               is_ws;
    logic               is_x;
    logic [5:0]         dig;

    assign is_ws = (item.ch == CHAR_SPACE) || (item.ch == CHAR_TAB);
    assign is_x  = (item.ch == CHAR_LC_X) || (item.ch == CHAR_UC_X);
    assign dig   = digit_of(item.ch);

    // One character through the prefix/sign/digit sequence
    always_comb begin
        ph   = st.phase;
        acc  = st.acc;
        neg  = st.negative;
        base = st.base;
        cnt  = st.consumed;
        done = 1'b0;
        inc  = 1'b0;
        emit = 1'b0;

        // new string restarts the parse with this character
        if (item.start_req) begin
            ph   = PH_SPACE;
            acc  = '0;
            neg  = 1'b0;
            cnt  = '0;
            base = (item.radix > BASE_MAX) ? BASE_MAX : item.radix;
        end

        if (ph == PH_IDLE) begin
            done = 1'b1;
        end

        // leading blanks and sign
        if (!done && ph == PH_SPACE) begin
            if (is_ws) begin
                inc  = 1'b1;
                done = 1'b1;
            end else begin
                ph = PH_BODY;
                if (item.ch == CHAR_MINUS) begin
                    neg  = 1'b1;
                    inc  = 1'b1;
                    done = 1'b1;
                end else if (item.ch == CHAR_PLUS) begin
                    inc  = 1'b1;
                    done = 1'b1;
                end
            end
        end

        // leading zero may open a hex or octal prefix
        if (!done && ph == PH_BODY) begin
            if ((base == BASE_AUTO || base == BASE_HEX) && item.ch == CHAR_ZERO) begin
                inc  = 1'b1;
                ph   = PH_ZERO;
                done = 1'b1;
            end else begin
                if (base == BASE_AUTO) begin
                    base = BASE_DEC;
                end
                ph = PH_DIGITS;
            end
        end

        if (!done && ph == PH_ZERO) begin
            if (is_x) begin
                base = BASE_HEX;
                inc  = 1'b1;
                ph   = PH_DIGITS;
                done = 1'b1;
            end else begin
                if (base == BASE_AUTO) begin
                    base = BASE_OCT;
                end
                ph = PH_DIGITS;
            end
        end

        // digit accumulate or stop
        if (!done) begin
            if (dig < base) begin
                acc = VALUE_W'(acc * VALUE_W'(base)) + VALUE_W'(dig);
                inc = 1'b1;
            end else begin
                emit = 1'b1;
                ph   = PH_IDLE;
            end
        end
    end

    // saturating character count
    always_comb begin
        st_next.phase    = ph;
        st_next.acc      = acc;
        st_next.negative = neg;
        st_next.base     = base;
        st_next.consumed = (inc && cnt < CNT_LIMIT) ? cnt + CNT_W'(1) : cnt;
    end

    assign result.value      = neg ? VALUE_W'(0) - acc : acc;
    assign result.end_offset = (CNT_W > OFFSET_W && cnt > CNT_W'(OFFSET_SAT)) ?
                               OFFSET_SAT : OFFSET_W'(cnt);

endmodule

/* rtl/integer_text_parser_unit.sv */
// Channel  Dir  Port group              Contents
// s_       in   tvalid/tready/tdata/    one character; tuser: start_req, radix
//               tuser
// m_       out  tvalid/tready/tdata     parsed value and end offset
//
// One character per cycle unless a stalled result holds the input register.
// The accumulator multiply-add by the base sits between the input register
// and the result register; parse state updates in the same cycle.
// Reset (aresetn low, synchronous) empties both registers and idles the parser.
// A stalled result holds the input register; s_tready drops only then.
module integer_text_parser_unit
    import itp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] ch
    input  logic [S_USER_W-1:0] s_tuser,   // [0] start_req, [6:1] radix
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [63:0] value, [79:64] end_offset
);

    in_item_t     s_item;
    in_item_t     cur_item;
    logic         cur_valid;
    logic         load;
    logic         advance;
    parse_state_t st_reg;
    parse_state_t st_next;
    logic         emit;
    result_t      result;
    logic         m_tvalid_reg;
    logic         m_tvalid_next;
    result_t      res_reg;

    assign s_item.ch        = s_tdata[7:0];
    assign s_item.start_req = s_tuser[0];
    assign s_item.radix     = s_tuser[RADIX_W:1];

    // Handshake: step runs when the result register is free or draining
    assign advance  = cur_valid && (!m_tvalid_reg || m_tready);
    assign s_tready = !cur_valid || advance;
    assign load     = s_tvalid && s_tready;

    itp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .item_in  (s_item),
        .advance  (advance),
        .valid    (cur_valid),
        .item_out (cur_item)
    );

    itp_step u_step (
        .st      (st_reg),
        .item    (cur_item),
        .st_next (st_next),
        .emit    (emit),
        .result  (result)
    );

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{phase: PH_IDLE, acc: '0, negative: 1'b0, base: '0, consumed: '0};
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // Result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = emit;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({res_reg.end_offset, res_reg.value});

endmodule

/* rtl/itp_checker.sv */
module itp_checker
    import itp_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [S_USER_W-1:0] s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // stalled result stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // stalled result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // input back-pressure only comes from a stalled result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // a fresh result must trace back to an input transfer through the input register
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding input transfer");

    // nothing consumed means nothing accumulated
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[VALUE_W +: OFFSET_W] == '0 |-> m_tdata[VALUE_W-1:0] == '0)
        else $error("nonzero value with zero offset");

endmodule

bind integer_text_parser_unit itp_checker u_itp_checker (.*);

/* bench/integer_text_parser_unit_tb.sv */
module integer_text_parser_unit_tb;
    import itp_pkg::*;

    // One stimulus character plus an optional hand-written expectation
    typedef struct packed {
        logic [7:0]          ch;
        logic                first;
        logic [RADIX_W-1:0]  radix;
        logic                typed;
        logic [VALUE_W-1:0]  want_value;
        logic [OFFSET_W-1:0] want_offset;
    } char_rec_t;

    // Scanner state as the parse walks a string
    typedef struct packed {
        phase_t              ph;
        logic [VALUE_W-1:0]  acc;
        logic                neg;
        logic [RADIX_W-1:0]  base;
        logic [OFFSET_W-1:0] cnt;
    } scan_state_t;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_EVERY4} rdy_mode_t;

    localparam int RANDOM_ITEMS = 1100;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [7:0] ch
    logic [S_USER_W-1:0] s_tuser;   // [0] start_req, [6:1] radix
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [63:0] value, [79:64] end_offset

    char_rec_t   stim_q [$];
    result_t     pending_nums [$];
    char_rec_t   directed_tbl [24];
    scan_state_t model_st;
    scan_state_t gen_st;
    int          stim_idx;
    int          live_items;
    int          mismatch_cnt;
    logic        running;
    logic        in_taken;
    int          burst_left;
    int          gap_left;
    rdy_mode_t   rdy_mode;
    int          rdy_left;
    logic [1:0]  rdy_phase;
    logic        seq_first;
    logic [5:0]  seq_radix;

    integer_text_parser_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic scan_state_t idle_state();
        scan_state_t s;
        s.ph   = PH_IDLE;
        s.acc  = '0;
        s.neg  = 1'b0;
        s.base = '0;
        s.cnt  = '0;
        return s;
    endfunction

    function automatic logic [OFFSET_W-1:0] sat_inc(input logic [OFFSET_W-1:0] n);
        return (n < OFFSET_W'(MAX_CHARS)) ? n + 1'b1 : n;
    endfunction

    // Weight of a character as a digit, NOT_DIGIT when it is none
    function automatic logic [5:0] char_weight(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return 6'(c - CHAR_ZERO);
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return 6'(c - CHAR_LC_A + 8'd10);
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return 6'(c - CHAR_UC_A + 8'd10);
        return NOT_DIGIT;
    endfunction

    // Advance the scanner by one character; 1 when it yields a number
    function automatic logic parse_step(inout scan_state_t st, input logic [7:0] c,
                                        input logic first, input logic [5:0] r,
                                        output result_t num);
        logic [5:0] w;
        num = '0;
        if (first) begin
            st.ph   = PH_SPACE;
            st.acc  = '0;
            st.neg  = 1'b0;
            st.cnt  = '0;
            st.base = (r > BASE_MAX) ? BASE_MAX : r;
        end
        if (st.ph == PH_IDLE) return 1'b0;
        // leading blanks, then one optional sign
        if (st.ph == PH_SPACE) begin
            if (c == CHAR_SPACE || c == CHAR_TAB) begin
                st.cnt = sat_inc(st.cnt);
                return 1'b0;
            end
            st.ph = PH_BODY;
            if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                st.neg = (c == CHAR_MINUS);
                st.cnt = sat_inc(st.cnt);
                return 1'b0;
            end
        end
        // a leading zero may open a hex prefix or mean octal
        if (st.ph == PH_BODY) begin
            if ((st.base == BASE_AUTO || st.base == BASE_HEX) && c == CHAR_ZERO) begin
                st.cnt = sat_inc(st.cnt);
                st.ph  = PH_ZERO;
                return 1'b0;
            end
            if (st.base == BASE_AUTO) st.base = BASE_DEC;
            st.ph = PH_DIGITS;
        end
        if (st.ph == PH_ZERO) begin
            if (c == CHAR_LC_X || c == CHAR_UC_X) begin
                st.base = BASE_HEX;
                st.cnt  = sat_inc(st.cnt);
                st.ph   = PH_DIGITS;
                return 1'b0;
            end
            if (st.base == BASE_AUTO) st.base = BASE_OCT;
            st.ph = PH_DIGITS;
        end
        w = char_weight(c);
        if (w < st.base) begin
            st.acc = st.acc * 64'(st.base) + 64'(w);
            st.cnt = sat_inc(st.cnt);
            return 1'b0;
        end
        num.value      = st.neg ? -st.acc : st.acc;
        num.end_offset = st.cnt;
        st.ph          = PH_IDLE;
        return 1'b1;
    endfunction

    task automatic report_err(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        $display("MISMATCH %s: expected %0h, got %0h (t=%0t)", what, want, got, $time);
        mismatch_cnt++;
    endtask

    // Queue one character; items the parser would drop while idle don't count
    task automatic push_char(input char_rec_t rec);
        result_t scratch;
        if (rec.first || gen_st.ph != PH_IDLE) live_items++;
        void'(parse_step(gen_st, rec.ch, rec.first, rec.radix, scratch));
        stim_q.push_back(rec);
    endtask

    task automatic emit(input logic [7:0] c);
        logic [5:0] r;
        r = seq_first ? seq_radix : 6'($urandom_range(0, 63));
        push_char('{c, seq_first, r, 1'b0, 64'd0, 16'd0});
        seq_first = 1'b0;
    endtask

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return CHAR_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CHAR_LC_A : CHAR_UC_A) + 8'(v - 10);
    endfunction

    // Well-formed number: blanks, sign, prefix, digits, random stopper or none
    task automatic gen_number();
        int eb;
        int n;
        seq_first = 1'b1;
        case ($urandom_range(0, 9))
            0, 1:    seq_radix = BASE_AUTO;
            2:       seq_radix = BASE_DEC;
            3:       seq_radix = BASE_HEX;
            4:       seq_radix = BASE_OCT;
            5:       seq_radix = 6'd2;
            6:       seq_radix = 6'd1;
            7:       seq_radix = BASE_MAX;
            8:       seq_radix = 6'($urandom_range(1, 36));
            default: seq_radix = 6'($urandom_range(37, 63));
        endcase
        eb = (seq_radix > BASE_MAX) ? 36 : int'(seq_radix);
        repeat ($urandom_range(0, 3)) emit($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        case ($urandom_range(0, 3))
            0:       emit(CHAR_MINUS);
            1:       emit(CHAR_PLUS);
            default: ;
        endcase
        if (eb == 0 || eb == 16) begin
            case ($urandom_range(0, 2))
                0: begin
                    emit(CHAR_ZERO);
                    emit($urandom_range(0, 1) ? CHAR_LC_X : CHAR_UC_X);
                    eb = 16;
                end
                1: begin
                    if (eb == 0) begin
                        emit(CHAR_ZERO);
                        eb = 8;
                    end
                end
                default: ;
            endcase
        end
        if (eb == 0) eb = 10;
        // long digit runs can push the accumulator past 64 bits
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
        repeat (n) emit(digit_char($urandom_range(0, eb - 1)));
        case ($urandom_range(0, 9))
            0:       ;   // truncated: the next start drops this parse
            1, 2, 3: emit(8'($urandom_range(0, 255)));
            4:       emit(8'h00);
            5:       emit(8'hFF);
            6:       emit(CHAR_SPACE);
            default: emit(";");
        endcase
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 6)) begin
            push_char('{8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                        6'($urandom_range(0, 63)), 1'b0, 64'd0, 16'd0});
        end
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(negedge aclk) begin
        if (running && !(s_tvalid && !in_taken)) begin
            if (stim_idx < stim_q.size() && gap_left == 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= stim_q[stim_idx].ch;
                s_tuser  <= {stim_q[stim_idx].radix, stim_q[stim_idx].first};
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 7) == 0) begin
                    burst_left = $urandom_range(64, 200);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // Receiver: switches between always ready, coin flip and one in four
    always @(negedge aclk) begin
        if (running) begin
            if (rdy_left == 0) begin
                rdy_mode = rdy_mode_t'($urandom_range(0, 2));
                rdy_left = $urandom_range(20, 200);
            end else begin
                rdy_left--;
            end
            rdy_phase = rdy_phase + 1'b1;
            case (rdy_mode)
                RDY_ALWAYS: m_tready <= 1'b1;
                RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                default:    m_tready <= (rdy_phase == 2'd0);
            endcase
        end
    end

    // Predict on each input transfer, check each result transfer
    always @(posedge aclk) begin
        char_rec_t rec;
        result_t   num;
        result_t   want;
        in_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                rec = stim_q[stim_idx];
                stim_idx++;
                if (parse_step(model_st, rec.ch, rec.first, rec.radix, num) || rec.typed) begin
                    if (rec.typed) begin
                        num.value      = rec.want_value;
                        num.end_offset = rec.want_offset;
                    end
                    pending_nums.push_back(num);
                end
            end
            if (m_tvalid && m_tready) begin
                if (pending_nums.size() == 0) begin
                    report_err("unexpected result", 64'd0, m_tdata[63:0]);
                end else begin
                    want = pending_nums.pop_front();
                    if (m_tdata[63:0] !== want.value)
                        report_err("value", want.value, m_tdata[63:0]);
                    if (m_tdata[79:64] !== want.end_offset)
                        report_err("end_offset", 64'(want.end_offset), 64'(m_tdata[79:64]));
                end
            end
        end
    end

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        running    = 1'b0;
        in_taken   = 1'b0;
        stim_idx   = 0;
        live_items = 0;
        mismatch_cnt = 0;
        burst_left = 1;
        gap_left   = 0;
        rdy_mode   = RDY_ALWAYS;
        rdy_left   = 0;
        rdy_phase  = '0;
        seq_first  = 1'b0;
        seq_radix  = BASE_AUTO;
        model_st   = idle_state();
        gen_st     = idle_state();

        // ch, start, radix, typed, value, end_offset
        directed_tbl = '{
            '{"q",        1'b0, BASE_AUTO, 1'b0, 64'd0,    16'd0},  // idle, no start: dropped
            '{CHAR_SPACE, 1'b1, BASE_DEC,  1'b0, 64'd0,    16'd0},
            '{CHAR_TAB,   1'b0, BASE_AUTO, 1'b0, 64'd0,    16'd0},
            '{CHAR_MINUS, 1'b0, BASE_AUTO, 1'b0, 64'd0,    16'd0},
            '{"7",        1'b0, BASE_AUTO, 1'b0, 64'd0,    16'd0},
            '{"z",        1'b0, BASE_AUTO, 1'b1, -64'd7,   16'd4},
            '{CHAR_ZERO,  1'b1, BASE_HEX,  1'b0, 64'd0,    16'd0},  // prefix with no digits
            '{CHAR_UC_X,  1'b0, BASE_AUTO, 1'b0, 64'd0,    16'd0},
            '{"G",        1'b0, BASE_AUTO, 1'b1, 64'd0,    16'd2},
            '{CHAR_ZERO,  1'b1, BASE_AUTO, 1'b0, 64'd0,    16'd0},  // auto octal
            '{"1",        1'b0, BASE_AUTO, 1'b0, 64'd0,    16'd0},
            '{"7",        1'b0, BASE_AUTO, 1'b0, 64'd0,    16'd0},
            '{8'h00,      1'b0, BASE_AUTO, 1'b1, 64'd15,   16'd3},
            '{CHAR_PLUS,  1'b1, BASE_DEC,  1'b0, 64'd0,    16'd0},  // blank after sign stops
            '{CHAR_SPACE, 1'b0, BASE_AUTO, 1'b1, 64'd0,    16'd1},
            '{"Z",        1'b1, 6'd63,     1'b0, 64'd0,    16'd0},  // oversized radix clamps
            '{"z",        1'b0, BASE_AUTO, 1'b0, 64'd0,    16'd0},
            '{"/",        1'b0, BASE_AUTO, 1'b1, 64'd1295, 16'd2},
            '{CHAR_ZERO,  1'b1, 6'd1,      1'b0, 64'd0,    16'd0},  // radix one
            '{"1",        1'b0, BASE_AUTO, 1'b1, 64'd0,    16'd1},
            '{"9",        1'b1, BASE_DEC,  1'b0, 64'd0,    16'd0},
            '{"8",        1'b1, BASE_DEC,  1'b0, 64'd0,    16'd0},  // restart drops the 9
            '{8'hFF,      1'b0, BASE_AUTO, 1'b1, 64'd8,    16'd1},
            '{8'hFF,      1'b1, BASE_AUTO, 1'b1, 64'd0,    16'd0}   // no digits at all
        };
        foreach (directed_tbl[i]) push_char(directed_tbl[i]);

        // random numbers with some noise mixed in
        begin
            int target;
            target = live_items + RANDOM_ITEMS;
            while (live_items < target) begin
                if ($urandom_range(0, 6) == 0) gen_noise();
                else gen_number();
            end
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        running <= 1'b1;

        while (stim_idx < stim_q.size()) @(posedge aclk);
        while (pending_nums.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("integer_text_parser_unit_tb OK");
        end else begin
            $display("integer_text_parser_unit_tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("integer_text_parser_unit_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/itp_pkg.sv
rtl/itp_in_reg.sv
rtl/itp_step.sv
rtl/integer_text_parser_unit.sv
rtl/itp_checker.sv
bench/integer_text_parser_unit_tb.sv
